/* hdl/pswt_pkg.sv */
`timescale 1ns / 1ps

package pswt_pkg;

  localparam int SEQ_W    = 16;
  localparam int SLOT_IN_W = 6;
  localparam int WINDOW_W = 32;
  localparam int COUNT_W  = 32;

  // Verdict codes
  localparam logic [2:0] VERDICT_FIRST   = 3'd0;
  localparam logic [2:0] VERDICT_FRESHER = 3'd1;
  localparam logic [2:0] VERDICT_DUP     = 3'd2;
  localparam logic [2:0] VERDICT_REORDER = 3'd3;
  localparam logic [2:0] VERDICT_OLD     = 3'd4;

  typedef struct packed {
    logic [SLOT_IN_W-1:0] peer_slot;
    logic [SEQ_W-1:0]     seq;
  } datagram_t;

  typedef struct packed {
    logic                accepted;
    logic [2:0]          verdict;
    logic [SEQ_W-1:0]    freshest_seq;
    logic [WINDOW_W-1:0] delivery_history;
    logic [COUNT_W-1:0]  reorder_total;
    logic [COUNT_W-1:0]  duplicate_total;
  } result_t;

  // One peer table row
  typedef struct packed {
    logic                seen;
    logic [SEQ_W-1:0]    freshest;
    logic [WINDOW_W-1:0] history;
    logic [COUNT_W-1:0]  reorder;
    logic [COUNT_W-1:0]  duplicate;
  } peer_row_t;

  // Classification passed back from the update logic
  typedef struct packed {
    logic       accepted;
    logic [2:0] verdict;
  } class_t;

endpackage

/* hdl/pswt_update.sv */
`timescale 1ns / 1ps

module pswt_update import pswt_pkg::*; (
  input  peer_row_t        row,
  input  logic [SEQ_W-1:0] seq,
  output peer_row_t        row_next,
  output class_t           cls
);

  logic [SEQ_W-1:0]    ahead;
  logic [SEQ_W-1:0]    back;
  logic [4:0]          step;
  logic [4:0]          back_idx;
  logic [WINDOW_W-1:0] back_bit;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == '1) ? v : v + COUNT_W'(1);
    return r;
  endfunction

  assign ahead    = seq - row.freshest;
  assign back     = row.freshest - seq;
  assign step     = ahead[4:0];
  assign back_idx = 5'(back[5:0] - 6'd1);
  assign back_bit = WINDOW_W'(1) << back_idx;

  always_comb begin
    row_next     = row;
    cls.accepted = 1'b0;
    cls.verdict  = VERDICT_OLD;
    if (!row.seen) begin
      // first word from this peer: set up the entry
      row_next.seen      = 1'b1;
      row_next.freshest  = seq;
      row_next.history   = '0;
      row_next.reorder   = '0;
      row_next.duplicate = '0;
      cls.accepted       = 1'b1;
      cls.verdict        = VERDICT_FIRST;
    end else if (ahead != '0 && !ahead[SEQ_W-1]) begin
      // advance the window
      if (ahead >= SEQ_W'(WINDOW_W)) begin
        row_next.history = '0;
      end else begin
        row_next.history = (row.history << step) | (WINDOW_W'(1) << 5'(step - 5'd1));
      end
      row_next.freshest = seq;
      cls.accepted      = 1'b1;
      cls.verdict       = VERDICT_FRESHER;
    end else if (back == '0) begin
      row_next.duplicate = sat_inc(row.duplicate);
      cls.verdict        = VERDICT_DUP;
    end else if (back <= SEQ_W'(WINDOW_W)) begin
      if ((row.history & back_bit) != '0) begin
        row_next.duplicate = sat_inc(row.duplicate);
        cls.verdict        = VERDICT_DUP;
      end else begin
        row_next.reorder = sat_inc(row.reorder);
        row_next.history = row.history | back_bit;
        cls.verdict      = VERDICT_REORDER;
      end
    end
  end

endmodule

/* hdl/per_peer_sequence_window_tracker.sv */
`timescale 1ns / 1ps
// A word accepted at a clock edge is registered into stage one while its row is read;
// the updated row and its result are then registered, and done goes high with the result.
// Throughput: one word per cycle while busy is low; the table reads one row and writes
// back another each cycle, and the row just written is forwarded to a following word on
// the same slot. Reset: synchronous; busy stays high while the table is swept.
// The receiver cannot stall: each result stands for exactly one cycle.

module per_peer_sequence_window_tracker import pswt_pkg::*; #(
  parameter int PEER_SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  datagram_t datagram,
  output logic      done,
  output result_t   result
);

  localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  // Peer table: one row per slot, seen mark held in the row itself
  peer_row_t table_mem [PEER_SLOTS];

  // Clearing sweep after reset
  logic              clearing;
  logic [SLOT_W-1:0] clr_addr;

  // Stage one: word whose row is being read back
  logic                 s1_valid;
  logic [SLOT_IN_W-1:0] s1_slot;
  logic [SEQ_W-1:0]     s1_seq;
  peer_row_t            rd_row;
  logic                 fwd;
  peer_row_t            fwd_row;

  logic                 take;
  logic [SLOT_W+SLOT_IN_W-1:0] in_slot_ext;
  logic [SLOT_W+SLOT_IN_W-1:0] s1_slot_ext;
  logic [SLOT_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]    s1_addr;
  logic                 s1_in_range;

  peer_row_t            cur_row;
  peer_row_t            upd_row;
  class_t               cls;

  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  peer_row_t            wr_row;
  logic                 item_wr;

  result_t              result_next;

  assign busy = clearing;
  assign take = start && !busy;

  assign in_slot_ext = {{SLOT_W{1'b0}}, datagram.peer_slot};
  assign s1_slot_ext = {{SLOT_W{1'b0}}, s1_slot};
  assign rd_addr     = in_slot_ext[SLOT_W-1:0];
  assign s1_addr     = s1_slot_ext[SLOT_W-1:0];
  assign s1_in_range = (32'(s1_slot) < PEER_SLOTS);

  // Take the row just written in place of the stale memory read
  assign cur_row = fwd ? fwd_row : rd_row;

  pswt_update u_update (
    .row      (cur_row),
    .seq      (s1_seq),
    .row_next (upd_row),
    .cls      (cls)
  );

  assign item_wr = s1_valid && s1_in_range;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_addr;
    wr_row  = upd_row;
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_row  = '0;
    end else if (item_wr) begin
      wr_en = 1'b1;
    end
  end

  // Peer table memory: read first, write back
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_row;
    end
    rd_row <= table_mem[rd_addr];
  end

  // Forward when the incoming word hits the slot being written this cycle
  always_ff @(posedge clk) begin
    fwd     <= item_wr && (s1_slot == datagram.peer_slot);
    fwd_row <= upd_row;
    s1_slot <= datagram.peer_slot;
    s1_seq  <= datagram.seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == SLOT_W'(PEER_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= take;
      done     <= s1_valid;
    end
  end

  // Build the result word; slots beyond the table give a bare too-old verdict
  always_comb begin
    result_next = '0;
    result_next.verdict = VERDICT_OLD;
    if (s1_in_range) begin
      result_next.accepted         = cls.accepted;
      result_next.verdict          = cls.verdict;
      result_next.freshest_seq     = upd_row.freshest;
      result_next.delivery_history = upd_row.history;
      result_next.reorder_total    = upd_row.reorder;
      result_next.duplicate_total  = upd_row.duplicate;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result <= result_next;
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import pswt_pkg::*;

  localparam int PEER_COUNT   = 64;
  localparam int RANDOM_WORDS = 680;
  localparam int STALL_LIMIT  = 1000;  // covers the table sweep after reset with a wide margin
  localparam int DRAIN_CYCLES = 8;     // quiet cycles watched for stray results after the last one
  localparam int CALM_FROM    = 250;   // random words in [CALM_FROM, CALM_TO) are sent back to back
  localparam int CALM_TO      = 420;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  datagram_t datagram = '0;
  logic      done;
  result_t   result;

  per_peer_sequence_window_tracker #(
    .PEER_SLOTS(PEER_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .datagram(datagram),
    .done(done),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Own copy of the per-peer receive state. freshest and window are only
  // meaningful once the peer's seen mark is set.
  logic                seen_mark   [PEER_COUNT];
  logic [SEQ_W-1:0]    top_seq     [PEER_COUNT];
  logic [WINDOW_W-1:0] window_map  [PEER_COUNT];
  logic [COUNT_W-1:0]  reorder_cnt [PEER_COUNT];
  logic [COUNT_W-1:0]  dup_cnt     [PEER_COUNT];

  result_t pending_results[$];
  int      errors;
  int      words_sent;
  int      results_seen;
  int      verdict_mix[5];
  int      quiet_cycles = 0;

  typedef struct {
    logic      typed;  // expectation typed into the row rather than predicted
    datagram_t word;
    result_t   want;
  } row_t;

  row_t directed_rows[$];

  // Classify one datagram against the peer's window and advance the peer state.
  function automatic result_t predict_datagram(input datagram_t word);
    result_t             r;
    int unsigned         slot;
    logic [SEQ_W-1:0]    ahead;
    logic [SEQ_W-1:0]    back;
    logic [WINDOW_W-1:0] hist;
    logic [WINDOW_W-1:0] mask;
    slot = word.peer_slot;
    r = '0;
    r.verdict = VERDICT_OLD;
    if (!seen_mark[slot]) begin
      seen_mark[slot]  = 1'b1;
      top_seq[slot]    = word.seq;
      window_map[slot] = '0;
      r.accepted = 1'b1;
      r.verdict  = VERDICT_FIRST;
    end else begin
      ahead = word.seq - top_seq[slot];
      back  = top_seq[slot] - word.seq;
      hist  = window_map[slot];
      if (ahead != 0 && ahead < 16'd32768) begin
        // advance the window; a jump of a whole window or more forgets it all
        if (ahead >= WINDOW_W)
          hist = '0;
        else
          hist = (hist << ahead) | (32'd1 << (ahead - 1));
        top_seq[slot]    = word.seq;
        window_map[slot] = hist;
        r.accepted = 1'b1;
        r.verdict  = VERDICT_FRESHER;
      end else if (back == 0) begin
        if (dup_cnt[slot] != '1) dup_cnt[slot] = dup_cnt[slot] + 1;
        r.verdict = VERDICT_DUP;
      end else if (back <= WINDOW_W) begin
        mask = 32'd1 << (back - 1);
        if ((hist & mask) != 0) begin
          if (dup_cnt[slot] != '1) dup_cnt[slot] = dup_cnt[slot] + 1;
          r.verdict = VERDICT_DUP;
        end else begin
          if (reorder_cnt[slot] != '1) reorder_cnt[slot] = reorder_cnt[slot] + 1;
          window_map[slot] = hist | mask;
          r.verdict = VERDICT_REORDER;
        end
      end
    end
    r.freshest_seq     = top_seq[slot];
    r.delivery_history = window_map[slot];
    r.reorder_total    = reorder_cnt[slot];
    r.duplicate_total  = dup_cnt[slot];
    return r;
  endfunction

  // Mostly well-formed traffic: a handful of busy peers whose sequence moves
  // just ahead of, onto or just behind the freshest; the rest is noise.
  function automatic datagram_t pick_word();
    datagram_t   w;
    int unsigned roll;
    w.peer_slot = ($urandom_range(0, 99) < 80) ? SLOT_IN_W'($urandom_range(0, 7))
                                               : SLOT_IN_W'($urandom_range(0, PEER_COUNT - 1));
    w.seq = SEQ_W'($urandom);
    if (seen_mark[w.peer_slot]) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)
        w.seq = top_seq[w.peer_slot] + SEQ_W'($urandom_range(1, 33));
      else if (roll < 45)
        w.seq = top_seq[w.peer_slot] + SEQ_W'($urandom_range(33, 32768));
      else if (roll < 88)
        w.seq = top_seq[w.peer_slot] - SEQ_W'($urandom_range(0, 34));
    end
    return w;
  endfunction

  task automatic add_row(input int slot, input int seq, input logic typed, input result_t want);
    row_t row;
    row.typed = typed;
    row.word.peer_slot = SLOT_IN_W'(slot);
    row.word.seq = SEQ_W'(seq);
    row.want = want;
    directed_rows = {directed_rows, row};
  endtask

  // Hold the word with start high until an edge finds busy low, then log its expectation.
  task automatic send_word(input datagram_t word, input logic typed, input result_t want);
    result_t guess;
    datagram <= word;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    guess = predict_datagram(word);
    pending_results = {pending_results, (typed ? want : guess)};
    words_sent++;
  endtask

  // Drop start for a cycle now and then; the calm stretch sends back to back.
  task automatic maybe_idle(input logic calm);
    if (!calm && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Take each result in the cycle its strobe is high and match it to the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      results_seen++;
      if (result.verdict < 5) verdict_mix[result.verdict]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %h", $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(result.accepted));
        check_field("verdict", 32'(want.verdict), 32'(result.verdict));
        check_field("freshest_seq", 32'(want.freshest_seq), 32'(result.freshest_seq));
        check_field("delivery_history", want.delivery_history, result.delivery_history);
        check_field("reorder_total", want.reorder_total, result.reorder_total);
        check_field("duplicate_total", want.duplicate_total, result.duplicate_total);
      end
    end
  end

  // Watchdog: any accepted word or returned result counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    datagram_t word;
    for (int i = 0; i < PEER_COUNT; i++) begin
      seen_mark[i]   = 1'b0;
      top_seq[i]     = '0;
      window_map[i]  = '0;
      reorder_cnt[i] = '0;
      dup_cnt[i]     = '0;
    end
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    foreach (verdict_mix[i]) verdict_mix[i] = 0;

    // Directed words. Fields: accepted, verdict, freshest, history, reorders, duplicates.
    // first word from a peer after reset
    add_row(0, 0, 1'b1, '{1'b1, VERDICT_FIRST, 16'd0, 32'd0, 32'd0, 32'd0});
    // same sequence again
    add_row(0, 0, 1'b1, '{1'b0, VERDICT_DUP, 16'd0, 32'd0, 32'd0, 32'd1});
    // step of one marks the old freshest in bit 0
    add_row(0, 1, 1'b1, '{1'b1, VERDICT_FRESHER, 16'd1, 32'd1, 32'd0, 32'd1});
    // step of a whole window clears the history
    add_row(0, 33, 1'b1, '{1'b1, VERDICT_FRESHER, 16'd33, 32'd0, 32'd0, 32'd1});
    // far edge of the window: late arrival fills the top bit
    add_row(0, 1, 1'b1, '{1'b0, VERDICT_REORDER, 16'd33, 32'h8000_0000, 32'd1, 32'd1});
    // and a replay of it is a duplicate
    add_row(0, 1, 1'b1, '{1'b0, VERDICT_DUP, 16'd33, 32'h8000_0000, 32'd1, 32'd2});
    // one past the window
    add_row(0, 0, 1'b1, '{1'b0, VERDICT_OLD, 16'd33, 32'h8000_0000, 32'd1, 32'd2});
    // largest forward step
    add_row(0, 32800, 1'b1, '{1'b1, VERDICT_FRESHER, 16'd32800, 32'd0, 32'd1, 32'd2});
    // exactly half the sequence space away counts as old
    add_row(0, 32, 1'b1, '{1'b0, VERDICT_OLD, 16'd32800, 32'd0, 32'd1, 32'd2});
    // top slot, top sequence, then wrap through zero
    add_row(63, 65535, 1'b1, '{1'b1, VERDICT_FIRST, 16'hFFFF, 32'd0, 32'd0, 32'd0});
    add_row(63, 0, 1'b1, '{1'b1, VERDICT_FRESHER, 16'd0, 32'd1, 32'd0, 32'd0});
    add_row(63, 65535, 1'b1, '{1'b0, VERDICT_DUP, 16'd0, 32'd1, 32'd0, 32'd1});
    add_row(63, 65534, 1'b1, '{1'b0, VERDICT_REORDER, 16'd0, 32'd3, 32'd1, 32'd1});
    // steps just short of a window shift bits out of the top
    add_row(63, 31, 1'b0, '0);
    add_row(63, 62, 1'b0, '0);
    add_row(63, 30, 1'b0, '0);
    add_row(63, 29, 1'b0, '0);
    // alternating bit patterns in both fields
    add_row(42, 16'hAAAA, 1'b1, '{1'b1, VERDICT_FIRST, 16'hAAAA, 32'd0, 32'd0, 32'd0});
    add_row(42, 16'h5555, 1'b1, '{1'b0, VERDICT_OLD, 16'hAAAA, 32'd0, 32'd0, 32'd0});
    add_row(21, 16'h5555, 1'b1, '{1'b1, VERDICT_FIRST, 16'h5555, 32'd0, 32'd0, 32'd0});
    add_row(21, 16'hD554, 1'b0, '0);
    add_row(21, 16'hD553, 1'b0, '0);
    add_row(21, 16'hD555, 1'b0, '0);

    // Keep reset high, then release it; the block then sweeps its table with busy high.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      maybe_idle(1'b0);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      word = pick_word();
      send_word(word, 1'b0, '0);
      maybe_idle(n >= CALM_FROM && n < CALM_TO);
    end
    start <= 1'b0;

    // Drain: wait for every expected word, then watch a few quiet cycles for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d datagrams sent across %0d peer slots, %0d results checked",
             words_sent, PEER_COUNT, results_seen);
    $display("verdicts: first %0d, fresher %0d, duplicate %0d, reordered %0d, too old %0d",
             verdict_mix[VERDICT_FIRST], verdict_mix[VERDICT_FRESHER], verdict_mix[VERDICT_DUP],
             verdict_mix[VERDICT_REORDER], verdict_mix[VERDICT_OLD]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pswt_pkg.sv
hdl/pswt_update.sv
hdl/per_peer_sequence_window_tracker.sv
tb/sv/tb.sv
